/* hw/rtl/dssa_pkg.sv */
// shared types, constants and register codes of the doppler speed session averager
package dssa_pkg;

	// field and state widths
	localparam int CountW = 16;
	localparam int SumW   = 16;
	localparam int ByteW  = 8;
	localparam int CfgW   = 16;
	localparam int IdxW   = 2;

	// serial units take one bit of the sum per cycle
	localparam int SerSteps = SumW;
	localparam int StepW    = $clog2(SerSteps);

	// register reset values
	localparam logic [ByteW-1:0] MaxSamplesRst  = ByteW'(100);
	localparam logic [ByteW-1:0] MaxMishapsRst  = ByteW'(6);
	localparam logic [SumW-1:0]  MinDistanceRst = SumW'(303);
	localparam logic [ByteW-1:0] MaxDeviationRst = ByteW'(3);

	// configuration register indexes
	typedef enum logic [IdxW-1:0] {
		REG_MAX_SAMPLES   = 2'd0,
		REG_MAX_MISHAPS   = 2'd1,
		REG_MIN_DISTANCE  = 2'd2,
		REG_MAX_DEVIATION = 2'd3
	} reg_idx_t;

	// session outcome codes
	typedef enum logic [2:0] {
		OUT_NONE     = 3'd0,
		OUT_TOO_MANY = 3'd1,
		OUT_TOO_SHORT = 3'd2,
		OUT_UNSTEADY = 3'd3,
		OUT_VALID    = 3'd4
	} outcome_t;

	// request to the serial accumulator
	typedef struct packed {
		logic             start;
		logic             clear;
		logic [ByteW-1:0] addend;
	} acc_req_t;

	// request to the serial divider
	typedef struct packed {
		logic             start;
		logic [SumW-1:0]  dividend;
		logic [ByteW-1:0] divisor;
	} div_req_t;

	// status of a serial unit
	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

endpackage

/* hw/rtl/dssa_serial_acc.sv */
// bit-serial accumulator holding the session pulse sum
module dssa_serial_acc (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dssa_pkg::acc_req_t          req,
	output dssa_pkg::unit_stat_t        stat,
	output logic [dssa_pkg::SumW-1:0]   sum
);

	logic [dssa_pkg::SumW-1:0]  sum_q;
	logic [dssa_pkg::SumW-1:0]  add_q;
	logic                       carry_q;
	logic [dssa_pkg::StepW-1:0] cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic                       bit_sum;
	logic                       bit_carry;

	// one full adder on the low bits
	assign bit_sum   = sum_q[0] ^ add_q[0] ^ carry_q;
	assign bit_carry = (sum_q[0] & add_q[0]) | (sum_q[0] & carry_q) | (add_q[0] & carry_q);

	// sum rotates right through the adder, lsb first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			add_q   <= '0;
			carry_q <= 1'b0;
			cnt_q   <= '0;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == dssa_pkg::StepW'(dssa_pkg::SerSteps - 1));
			if (req.clear) begin
				sum_q  <= '0;
				busy_q <= 1'b0;
			end else if (req.start) begin
				add_q   <= dssa_pkg::SumW'(req.addend);
				carry_q <= 1'b0;
				cnt_q   <= '0;
				busy_q  <= 1'b1;
			end else if (busy_q) begin
				sum_q   <= {bit_sum, sum_q[dssa_pkg::SumW-1:1]};
				add_q   <= {1'b0, add_q[dssa_pkg::SumW-1:1]};
				carry_q <= bit_carry;
				cnt_q   <= cnt_q + 1'b1;
				if (cnt_q == dssa_pkg::StepW'(dssa_pkg::SerSteps - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign sum       = sum_q;

endmodule

/* hw/rtl/dssa_serial_div.sv */
// restoring divider, one quotient bit per cycle
module dssa_serial_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dssa_pkg::div_req_t          req,
	output dssa_pkg::unit_stat_t        stat,
	output logic [dssa_pkg::SumW-1:0]   quotient
);

	logic [dssa_pkg::SumW-1:0]  dvd_q;
	logic [dssa_pkg::ByteW-1:0] dsr_q;
	logic [dssa_pkg::ByteW-1:0] rem_q;
	logic [dssa_pkg::StepW-1:0] cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [dssa_pkg::ByteW:0]   rem_shift;
	logic [dssa_pkg::ByteW:0]   rem_next;
	logic                       fits;

	// trial subtract of the divisor from the shifted remainder
	always_comb begin
		rem_shift = {rem_q, dvd_q[dssa_pkg::SumW-1]};
		fits      = rem_shift >= {1'b0, dsr_q};
		rem_next  = fits ? (rem_shift - {1'b0, dsr_q}) : rem_shift;
	end

	// dividend shifts out msb first, quotient bits shift in at the lsb
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvd_q  <= '0;
			dsr_q  <= '0;
			rem_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == dssa_pkg::StepW'(dssa_pkg::SerSteps - 1));
			if (req.start) begin
				dvd_q  <= req.dividend;
				dsr_q  <= req.divisor;
				rem_q  <= '0;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				dvd_q <= {dvd_q[dssa_pkg::SumW-2:0], fits};
				rem_q <= rem_next[dssa_pkg::ByteW-1:0];
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == dssa_pkg::StepW'(dssa_pkg::SerSteps - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = dvd_q;

endmodule

/* hw/rtl/doppler_speed_session_averager_unit.sv */
// top level of the doppler speed session averager: session control and result register
//
// Takes one gate-window pulse count per request and closes a session on a run of
// bad windows or on the good-sample limit, giving one result (outcome, mean) per
// closed session. A good window waits for the bit-serial adder that adds the
// count into the 16-bit pulse sum one bit per cycle. A session closed as valid
// waits for the restoring divider that forms the mean one quotient bit per
// cycle. The result sits in an output register, so a waiting result stalls
// the input only when the next request also closes a session.
module doppler_speed_session_averager_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write port
	input  logic                              cfg_write_en,
	input  logic [dssa_pkg::IdxW-1:0]         cfg_index,
	input  logic [dssa_pkg::CfgW-1:0]         cfg_data,
	// window channel
	input  logic                              item_valid,
	output logic                              item_stall,
	input  logic [dssa_pkg::CountW-1:0]       pulse_count,
	input  logic                              unstable,
	// result channel
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic [2:0]                        outcome,
	output logic [dssa_pkg::ByteW-1:0]        mean_speed
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ADD,
		ST_DIV,
		ST_PUT
	} state_t;

	state_t state_q;

	// configuration registers
	logic [dssa_pkg::ByteW-1:0] max_samples_q;
	logic [dssa_pkg::ByteW-1:0] max_mishaps_q;
	logic [dssa_pkg::SumW-1:0]  min_distance_q;
	logic [dssa_pkg::ByteW-1:0] max_deviation_q;

	// session state
	logic [dssa_pkg::ByteW-1:0] mishap_run_q;
	logic [dssa_pkg::ByteW-1:0] good_count_q;
	logic [dssa_pkg::ByteW-1:0] previous_q;
	logic [dssa_pkg::ByteW-1:0] largest_q;

	// pending and delivered result
	dssa_pkg::outcome_t         res_code_q;
	logic [dssa_pkg::ByteW-1:0] res_mean_q;
	logic                       out_valid_q;
	dssa_pkg::outcome_t         out_code_q;
	logic [dssa_pkg::ByteW-1:0] out_mean_q;

	// serial units
	dssa_pkg::acc_req_t         acc_req;
	dssa_pkg::unit_stat_t       acc_stat;
	logic [dssa_pkg::SumW-1:0]  pulse_sum;
	dssa_pkg::div_req_t         div_req;
	dssa_pkg::unit_stat_t       div_stat;
	logic [dssa_pkg::SumW-1:0]  quotient;

	// window classification
	logic                       accept;
	logic                       bad;
	logic [dssa_pkg::ByteW-1:0] count8;
	logic [dssa_pkg::ByteW-1:0] mishap_next;
	logic                       mishap_close;
	logic [dssa_pkg::ByteW-1:0] good_next;
	logic                       sample_close;
	logic [dssa_pkg::ByteW-1:0] diff;
	logic                       go_divide;
	logic                       clear_session;
	logic                       out_free;

	assign accept     = item_valid && !item_stall;
	assign item_stall = (state_q != ST_IDLE);
	assign out_free   = !out_valid_q || !result_stall;

	// classify the window and evaluate both session limits
	always_comb begin
		count8       = pulse_count[dssa_pkg::ByteW-1:0];
		bad          = unstable || (|pulse_count[dssa_pkg::CountW-1:dssa_pkg::ByteW]) ||
		               (pulse_count == dssa_pkg::CountW'(1));
		mishap_next  = mishap_run_q + 1'b1;
		mishap_close = !(mishap_next < max_mishaps_q);
		good_next    = good_count_q + 1'b1;
		sample_close = (good_next >= max_samples_q);
		diff         = (count8 >= previous_q) ? (count8 - previous_q) : (previous_q - count8);
		go_divide    = accept && bad && mishap_close && (good_count_q != '0) &&
		               !(pulse_sum < min_distance_q) && !(largest_q > max_deviation_q);
		clear_session = accept && ((bad && mishap_close) || (!bad && sample_close));
	end

	// requests to the serial units
	always_comb begin
		acc_req.start    = accept && !bad && !sample_close;
		acc_req.clear    = clear_session;
		acc_req.addend   = count8;
		div_req.start    = go_divide;
		div_req.dividend = pulse_sum;
		div_req.divisor  = good_count_q;
	end

	dssa_serial_acc u_acc (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (acc_req),
		.stat   (acc_stat),
		.sum    (pulse_sum)
	);

	dssa_serial_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.stat     (div_stat),
		.quotient (quotient)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_samples_q   <= dssa_pkg::MaxSamplesRst;
			max_mishaps_q   <= dssa_pkg::MaxMishapsRst;
			min_distance_q  <= dssa_pkg::MinDistanceRst;
			max_deviation_q <= dssa_pkg::MaxDeviationRst;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				dssa_pkg::REG_MAX_SAMPLES:   max_samples_q   <= cfg_data[dssa_pkg::ByteW-1:0];
				dssa_pkg::REG_MAX_MISHAPS:   max_mishaps_q   <= cfg_data[dssa_pkg::ByteW-1:0];
				dssa_pkg::REG_MIN_DISTANCE:  min_distance_q  <= cfg_data[dssa_pkg::SumW-1:0];
				dssa_pkg::REG_MAX_DEVIATION: max_deviation_q <= cfg_data[dssa_pkg::ByteW-1:0];
			endcase
		end
	end

	// session control, state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			mishap_run_q <= '0;
			good_count_q <= '0;
			previous_q   <= '0;
			largest_q    <= '0;
			res_code_q   <= dssa_pkg::OUT_NONE;
			res_mean_q   <= '0;
			out_valid_q  <= 1'b0;
			out_code_q   <= dssa_pkg::OUT_NONE;
			out_mean_q   <= '0;
		end else begin
			// a taken result empties the output register unless the next one moves in
			if (out_valid_q && !result_stall && (state_q != ST_PUT)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (bad) begin
							if (!mishap_close) begin
								mishap_run_q <= mishap_next;
							end else begin
								res_mean_q <= '0;
								priority if (good_count_q == '0) begin
									res_code_q <= dssa_pkg::OUT_NONE;
									state_q    <= ST_PUT;
								end else if (pulse_sum < min_distance_q) begin
									res_code_q <= dssa_pkg::OUT_TOO_SHORT;
									state_q    <= ST_PUT;
								end else if (largest_q > max_deviation_q) begin
									res_code_q <= dssa_pkg::OUT_UNSTEADY;
									state_q    <= ST_PUT;
								end else begin
									res_code_q <= dssa_pkg::OUT_VALID;
									state_q    <= ST_DIV;
								end
							end
						end else if (sample_close) begin
							res_code_q <= dssa_pkg::OUT_TOO_MANY;
							res_mean_q <= '0;
							state_q    <= ST_PUT;
						end else begin
							good_count_q <= good_next;
							previous_q   <= count8;
							mishap_run_q <= '0;
							if ((good_count_q != '0) && (diff > largest_q)) begin
								largest_q <= diff;
							end
							state_q <= ST_ADD;
						end
						// closing a session clears it whatever the outcome
						if (clear_session) begin
							mishap_run_q <= '0;
							good_count_q <= '0;
							previous_q   <= '0;
							largest_q    <= '0;
						end
					end
				end
				ST_ADD: begin
					if (acc_stat.done) begin
						state_q <= ST_IDLE;
					end
				end
				ST_DIV: begin
					if (div_stat.done) begin
						res_mean_q <= quotient[dssa_pkg::ByteW-1:0];
						state_q    <= ST_PUT;
					end
				end
				ST_PUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_code_q  <= res_code_q;
						out_mean_q  <= res_mean_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result_valid = out_valid_q;
	assign outcome      = out_code_q;
	assign mean_speed   = out_mean_q;

	// the two serial units never run at the same time
	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(acc_stat.busy && div_stat.busy))
		else $error("accumulator and divider busy together");

	// a new request only starts with both units at rest
	a_idle_units_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!acc_stat.busy && !div_stat.busy))
		else $error("serial unit still busy while taking requests");

	// a finished division only lands while waiting for it
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == ST_DIV))
		else $error("divider finished outside the divide phase");

	// the good count never wraps, the sample limit closes first
	a_good_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		good_count_q != '1)
		else $error("good window count reached its wrap point");

	// only a valid session carries a mean
	a_mean_only_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_code_q != dssa_pkg::OUT_VALID)) |-> (out_mean_q == '0))
		else $error("mean given on a session that is not valid");

endmodule
